>>> rtl/usage_session_tracker_macros.svh
// Assertion macros shared by the usage session tracker checker.
`ifndef USAGE_SESSION_TRACKER_MACROS_SVH
`define USAGE_SESSION_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ust_checker: same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define UST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ust_checker: next-cycle property violated");

`endif

>>> rtl/ust_pkg.sv
// Types, constants and register indexes for the usage session tracker.
`default_nettype none

package ust_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int SUM_W         = 40;
  localparam int DUR_W         = 23;
  localparam int MS_PER_SECOND = 1000;

  // Shared divider: dividend covers the load sum, divisor covers the sample
  // count and the millisecond-per-second constant.
  localparam int DIV_N     = SUM_W;
  localparam int DIV_DW    = (COUNT_BITS > 10) ? COUNT_BITS : 10;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TIMEOUT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SESSION_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_PER_COUNT = 3'd4;

  localparam logic [15:0] RST_WEIGHT_THRESHOLD   = 16'd500;
  localparam logic [15:0] RST_START_DELAY_MS     = 16'd2000;
  localparam logic [15:0] RST_END_TIMEOUT_MS     = 16'd5000;
  localparam logic [31:0] RST_MIN_SESSION_MS     = 32'd10000;
  localparam logic [15:0] RST_DISTANCE_PER_COUNT = 16'd256;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [15:0]        total_weight;
    logic signed [31:0] encoder_position;
  } in_item_t;

  typedef struct packed {
    logic             in_use;
    logic             session_ended;
    logic             session_saved;
    logic [DUR_W-1:0] duration_s;
    logic [31:0]      session_distance;
    logic [15:0]      average_weight;
    logic [15:0]      peak_weight;
    logic [15:0]      sessions_today;
    logic [31:0]      distance_today;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_N-1:0]  dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ust_divider.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module ust_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ust_pkg::div_req_t req_i,
  output ust_pkg::div_rsp_t rsp_o
);
  import ust_pkg::*;

  logic [DIV_N-1:0]     quo_q;
  logic [DIV_DW-1:0]    rem_q;
  logic [DIV_DW-1:0]    divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  logic [DIV_DW:0] rem_shift;
  logic [DIV_DW:0] rem_diff;
  logic            fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIV_N-1]};
    rem_diff  = rem_shift - {1'b0, divisor_q};
    fits      = rem_shift >= {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= DIV_CNT_W'(DIV_N);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // The quotient shifts in from the bottom as the dividend shifts out the top.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_N-2:0], fits};
      rem_q <= fits ? rem_diff[DIV_DW-1:0] : rem_shift[DIV_DW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/usage_session_tracker.sv
// Usage session tracker: one sensor sample per item in, one status item out per sample.
// A sample is taken when in_stall_o is low and processed by a small sequencer; the
// result sits in an output register, so the next sample can be taken while it waits.
// A sample that does not close a session is evaluated and its result is written to the
// output register; a loaded sample during a session also goes through delta, magnitude,
// 32x16 multiply, then accumulate. A sample that closes a session runs the shared
// restoring divider (one quotient bit per cycle over a 40-bit dividend) for the duration
// in seconds and again for the average load, or only once when the session holds no
// samples. A stalled output holds a finished sample back only while the previous item
// still waits in the output register.
// Configuration writes are taken at any time and must only be issued while the block
// is idle.
`default_nettype none

module usage_session_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ust_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ust_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_we_i,
  input  logic [ust_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ust_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ust_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MAG,
    S_MUL,
    S_ACC,
    S_DIV_TIME,
    S_WAIT_TIME,
    S_DIV_AVG,
    S_WAIT_AVG,
    S_CLOSE,
    S_DONE
  } state_e;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration
  logic [15:0] thr_q, start_delay_q, end_timeout_q, dist_per_count_q;
  logic [31:0] min_session_q;

  // Session state
  state_e                state_q;
  logic                  active_q, load_seen_q;
  logic [31:0]           last_load_q, start_time_q, prev_pos_q, dist_q, daily_q;
  logic [SUM_W-1:0]      sum_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [15:0]           peak_q, saved_count_q;

  // Per-item work registers
  in_item_t         item_q;
  logic [31:0]      delta_q, mag_q, elapsed_q;
  logic [47:0]      prod_q;
  logic             ended_q, saved_q;
  logic [DUR_W-1:0] dur_q;
  logic [15:0]      avg_q;
  out_item_t        out_q;
  logic             out_valid_q;

  logic             loaded;
  logic [31:0]      since_load;
  logic [31:0]      delta_raw;
  logic [48:0]      dist_sum;
  logic [SUM_W:0]   sum_next;
  logic [32:0]      daily_sum;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_comb begin
    loaded     = item_q.total_weight > thr_q;
    since_load = item_q.time_ms - last_load_q;
    delta_raw  = $unsigned(item_q.encoder_position) - prev_pos_q;
    dist_sum   = 49'(dist_q) + 49'(prod_q);
    sum_next   = {1'b0, sum_q} + (SUM_W + 1)'(item_q.total_weight);
    daily_sum  = {1'b0, daily_q} + {1'b0, dist_q};
  end

  always_comb begin
    div_req.start = (state_q == S_DIV_TIME) || (state_q == S_DIV_AVG);
    if (state_q == S_DIV_AVG) begin
      div_req.dividend = sum_q;
      div_req.divisor  = DIV_DW'(count_q);
    end else begin
      div_req.dividend = DIV_N'(elapsed_q);
      div_req.divisor  = DIV_DW'(MS_PER_SECOND);
    end
  end

  ust_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q            <= RST_WEIGHT_THRESHOLD;
      start_delay_q    <= RST_START_DELAY_MS;
      end_timeout_q    <= RST_END_TIMEOUT_MS;
      min_session_q    <= RST_MIN_SESSION_MS;
      dist_per_count_q <= RST_DISTANCE_PER_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WEIGHT_THRESHOLD:   thr_q            <= cfg_data_i[15:0];
        CFG_START_DELAY_MS:     start_delay_q    <= cfg_data_i[15:0];
        CFG_END_TIMEOUT_MS:     end_timeout_q    <= cfg_data_i[15:0];
        CFG_MIN_SESSION_MS:     min_session_q    <= cfg_data_i;
        CFG_DISTANCE_PER_COUNT: dist_per_count_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      active_q      <= 1'b0;
      load_seen_q   <= 1'b0;
      last_load_q   <= '0;
      start_time_q  <= '0;
      prev_pos_q    <= '0;
      dist_q        <= '0;
      sum_q         <= '0;
      count_q       <= '0;
      peak_q        <= '0;
      saved_count_q <= '0;
      daily_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled instead of cleared.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            ended_q <= 1'b0;
            saved_q <= 1'b0;
            dur_q   <= '0;
            avg_q   <= '0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!active_q) begin
            if (loaded) begin
              if (!load_seen_q) begin
                load_seen_q <= 1'b1;
                last_load_q <= item_q.time_ms;
              end else if (since_load > 32'(start_delay_q)) begin
                active_q     <= 1'b1;
                start_time_q <= item_q.time_ms;
                prev_pos_q   <= $unsigned(item_q.encoder_position);
                dist_q       <= '0;
                sum_q        <= '0;
                count_q      <= '0;
                peak_q       <= '0;
              end
            end else begin
              load_seen_q <= 1'b0;
            end
            state_q <= S_DONE;
          end else if (loaded) begin
            delta_q <= delta_raw;
            state_q <= S_MAG;
          end else if (since_load > 32'(end_timeout_q)) begin
            elapsed_q <= item_q.time_ms - start_time_q;
            state_q   <= S_DIV_TIME;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MAG: begin
          // The most negative delta negates to itself, which is its magnitude.
          mag_q   <= delta_q[31] ? (32'd0 - delta_q) : delta_q;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= 48'(mag_q) * 48'(dist_per_count_q);
          state_q <= S_ACC;
        end
        S_ACC: begin
          dist_q      <= (dist_sum[48:32] != '0) ? 32'hFFFF_FFFF : dist_sum[31:0];
          prev_pos_q  <= $unsigned(item_q.encoder_position);
          last_load_q <= item_q.time_ms;
          if (count_q != COUNT_MAX) begin
            count_q <= count_q + COUNT_BITS'(1);
            sum_q   <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
          end
          if (item_q.total_weight > peak_q) begin
            peak_q <= item_q.total_weight;
          end
          state_q <= S_DONE;
        end
        S_DIV_TIME: begin
          state_q <= S_WAIT_TIME;
        end
        S_WAIT_TIME: begin
          if (div_rsp.done) begin
            dur_q   <= div_rsp.quotient[DUR_W-1:0];
            saved_q <= elapsed_q >= min_session_q;
            state_q <= (count_q == '0) ? S_CLOSE : S_DIV_AVG;
          end
        end
        S_DIV_AVG: begin
          state_q <= S_WAIT_AVG;
        end
        S_WAIT_AVG: begin
          if (div_rsp.done) begin
            avg_q   <= div_rsp.quotient[15:0];
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          active_q <= 1'b0;
          ended_q  <= 1'b1;
          if (saved_q) begin
            daily_q <= daily_sum[32] ? 32'hFFFF_FFFF : daily_sum[31:0];
            if (saved_count_q != 16'hFFFF) begin
              saved_count_q <= saved_count_q + 16'd1;
            end
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Wait until the output register is free or being emptied this cycle.
          if (!out_valid_q || !out_stall_i) begin
            out_q.in_use           <= active_q;
            out_q.session_ended    <= ended_q;
            out_q.session_saved    <= saved_q;
            out_q.duration_s       <= dur_q;
            out_q.session_distance <= ended_q ? dist_q : '0;
            out_q.average_weight   <= avg_q;
            out_q.peak_weight      <= ended_q ? peak_q : '0;
            out_q.sessions_today   <= saved_count_q;
            out_q.distance_today   <= daily_q;
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/ust_checker.sv
// Port-level checker for the usage session tracker, bound to the top level.
`default_nettype none

`include "usage_session_tracker_macros.svh"

module ust_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ust_pkg::out_item_t out_item_o
);
  import ust_pkg::*;

  `UST_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `UST_ASSERT_NEXT(a_out_item_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  // A closing sample always leaves the block idle.
  `UST_ASSERT_SAME(a_end_leaves_idle, clk_i, rst_ni, out_valid_o && out_item_o.session_ended, !out_item_o.in_use)
  `UST_ASSERT_SAME(a_saved_needs_end, clk_i, rst_ni, out_valid_o && out_item_o.session_saved, out_item_o.session_ended)
  // Items are processed one at a time, so the input stalls right after an accept.
  `UST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind usage_session_tracker ust_checker u_ust_checker (.*);

`default_nettype wire

>>> sim/tb.sv
// Testbench for the usage session tracker: directed and random samples checked by a scoreboard.
`default_nettype none

module tb;
  import ust_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Keeps its own copy of the tracker state and settings, predicts one status item per
  // accepted sample and checks the status items in order.
  class session_scoreboard;
    logic [15:0] thr, start_delay, end_timeout, dist_per_count;
    logic [31:0] min_ms;
    logic active, load_seen;
    logic [31:0] last_load_t, start_t, prev_pos, dist_acc, daily_dist;
    logic [39:0] load_sum;
    logic [COUNT_BITS-1:0] n_samples;
    logic [15:0] peak, saved_n;
    out_item_t expected_status_q[$];
    int errors;

    function new();
      thr = RST_WEIGHT_THRESHOLD;
      start_delay = RST_START_DELAY_MS;
      end_timeout = RST_END_TIMEOUT_MS;
      min_ms = RST_MIN_SESSION_MS;
      dist_per_count = RST_DISTANCE_PER_COUNT;
      active = 1'b0;
      load_seen = 1'b0;
      last_load_t = '0;
      start_t = '0;
      prev_pos = '0;
      dist_acc = '0;
      daily_dist = '0;
      load_sum = '0;
      n_samples = '0;
      peak = '0;
      saved_n = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WEIGHT_THRESHOLD: thr = data[15:0];
        CFG_START_DELAY_MS: start_delay = data[15:0];
        CFG_END_TIMEOUT_MS: end_timeout = data[15:0];
        CFG_MIN_SESSION_MS: min_ms = data;
        CFG_DISTANCE_PER_COUNT: dist_per_count = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_add32(logic [31:0] a, logic [63:0] b);
      logic [64:0] total;
      total = 65'(a) + 65'(b);
      return (total > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function void note_sample(in_item_t s);
      out_item_t r;
      logic loaded;
      logic [31:0] gap, delta, mag, elapsed;
      logic [40:0] load_total;
      logic [39:0] quo;
      r = '0;
      loaded = s.total_weight > thr;
      gap = s.time_ms - last_load_t;
      if (!active) begin
        if (loaded) begin
          if (!load_seen) begin
            load_seen = 1'b1;
            last_load_t = s.time_ms;
          end else if (gap > 32'(start_delay)) begin
            active = 1'b1;
            start_t = s.time_ms;
            prev_pos = s.encoder_position;
            dist_acc = '0;
            load_sum = '0;
            n_samples = '0;
            peak = '0;
          end
        end else begin
          load_seen = 1'b0;
        end
      end else if (loaded) begin
        delta = s.encoder_position - prev_pos;
        // Negating the most negative delta leaves 2^31, which is the wanted magnitude.
        mag = delta[31] ? -delta : delta;
        dist_acc = sat_add32(dist_acc, 64'(mag) * 64'(dist_per_count));
        prev_pos = s.encoder_position;
        if (n_samples != '1) begin
          n_samples++;
          load_total = 41'(load_sum) + 41'(s.total_weight);
          load_sum = load_total[40] ? '1 : load_total[39:0];
        end
        if (s.total_weight > peak) peak = s.total_weight;
        last_load_t = s.time_ms;
      end else if (gap > 32'(end_timeout)) begin
        elapsed = s.time_ms - start_t;
        r.session_ended = 1'b1;
        r.duration_s = DUR_W'(elapsed / MS_PER_SECOND);
        r.session_distance = dist_acc;
        if (n_samples != '0) begin
          quo = load_sum / 40'(n_samples);
          r.average_weight = quo[15:0];
        end
        r.peak_weight = peak;
        if (elapsed >= min_ms) begin
          r.session_saved = 1'b1;
          daily_dist = sat_add32(daily_dist, 64'(dist_acc));
          if (saved_n != '1) saved_n++;
        end
        active = 1'b0;
      end
      r.in_use = active;
      r.sessions_today = saved_n;
      r.distance_today = daily_dist;
      expected_status_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("tb: mismatch: %s", msg);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) report($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status_q.size() == 0) begin
        report("status item with no sample pending");
        return;
      end
      want = expected_status_q.pop_front();
      check_field("in_use", 64'(want.in_use), 64'(got.in_use));
      check_field("session_ended", 64'(want.session_ended), 64'(got.session_ended));
      check_field("session_saved", 64'(want.session_saved), 64'(got.session_saved));
      check_field("duration_s", 64'(want.duration_s), 64'(got.duration_s));
      check_field("session_distance", 64'(want.session_distance),
                  64'(got.session_distance));
      check_field("average_weight", 64'(want.average_weight), 64'(got.average_weight));
      check_field("peak_weight", 64'(want.peak_weight), 64'(got.peak_weight));
      check_field("sessions_today", 64'(want.sessions_today), 64'(got.sessions_today));
      check_field("distance_today", 64'(want.distance_today), 64'(got.distance_today));
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int unsigned cycles = 0;
  session_scoreboard sb;

  // Sample generator state.
  logic [31:0] gen_time, gen_pos;
  logic [15:0] gen_thr;
  int unsigned gen_span;
  logic gen_loaded = 1'b0;
  int run_left = 0;

  always #2 clk_i = ~clk_i;

  usage_session_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_status(out_item);
    out_stall <= rst_ni && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic drive_sample(logic [31:0] t, logic [15:0] w, logic [31:0] p);
    in_item_t s;
    s.time_ms = t;
    s.total_weight = w;
    s.encoder_position = p;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= s;
    do @(posedge clk_i); while (in_stall);
    sb.note_sample(s);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [15:0] thr, logic [15:0] start_delay,
                            logic [15:0] end_timeout, logic [31:0] min_ms,
                            logic [15:0] dist_pc);
    wait_idle();
    cfg_write(CFG_WEIGHT_THRESHOLD, 32'(thr));
    cfg_write(CFG_START_DELAY_MS, 32'(start_delay));
    cfg_write(CFG_END_TIMEOUT_MS, 32'(end_timeout));
    cfg_write(CFG_MIN_SESSION_MS, min_ms);
    cfg_write(CFG_DISTANCE_PER_COUNT, 32'(dist_pc));
    // Writes to unused indexes must leave every setting alone.
    cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_DISTANCE_PER_COUNT) + 1,
                                        (1 << CFG_IDX_W) - 1)), $urandom);
    cfg_we <= 1'b0;
    gen_thr = thr;
    gen_span = 32'((start_delay > end_timeout) ? start_delay : end_timeout) / 4 + 8;
  endtask

  task automatic run_phase(int n_items, idle_mode_e mode);
    logic [31:0] t, p;
    logic [15:0] w;
    case (mode)
      IDLE_NONE: begin src_idle_pct = 0; sink_stall_pct = 0; end
      IDLE_SENDER: begin src_idle_pct = 52; sink_stall_pct = 0; end
      IDLE_RECEIVER: begin src_idle_pct = 0; sink_stall_pct = 52; end
      default: begin src_idle_pct = 8; sink_stall_pct = 8; end
    endcase
    repeat (n_items) begin
      if ($urandom_range(99) < 8) begin
        // Noise: a sample out of sequence with fully random fields.
        t = $urandom;
        w = 16'($urandom);
        p = $urandom;
      end else begin
        // Alternate runs of loaded and unloaded samples so sessions open and close.
        if (run_left == 0) begin
          gen_loaded = !gen_loaded;
          run_left = gen_loaded ? $urandom_range(1, 24) : $urandom_range(1, 16);
        end
        run_left--;
        gen_time = gen_time + $urandom_range(0, gen_span);
        if ($urandom_range(19) == 0) gen_pos = $urandom;
        else gen_pos = gen_pos + $urandom_range(0, 400) - 32'd200;
        if ($urandom_range(9) == 0)
          w = (gen_thr == 16'hFFFF) ? gen_thr : gen_thr + 16'($urandom_range(0, 1));
        else if (gen_loaded && gen_thr != 16'hFFFF)
          w = 16'($urandom_range(int'(gen_thr) + 1, 65535));
        else
          w = 16'($urandom_range(0, int'(gen_thr)));
        t = gen_time;
        p = gen_pos;
      end
      drive_sample(t, w, p);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gen_thr = RST_WEIGHT_THRESHOLD;
    gen_span = 32'(RST_END_TIMEOUT_MS) / 4 + 8;
    gen_time = $urandom;
    gen_pos = $urandom;
    src_idle_pct = 8;
    sink_stall_pct = 8;

    // Directed samples under the reset settings.
    drive_sample(32'd0, 16'd0, 32'd0);
    drive_sample(32'd10, 16'd500, 32'd0);                 // load equal to threshold
    drive_sample(32'd20, 16'd501, 32'd100);               // load first seen
    drive_sample(32'd2020, 16'hFFFF, 32'd200);            // exactly the start delay
    drive_sample(32'd2021, 16'd600, 32'h8000_0000);       // session starts
    drive_sample(32'd3000, 16'hFFFF, 32'h7FFF_FFFF);
    drive_sample(32'd4000, 16'd501, 32'hFFFF_FFFF);       // most negative delta, saturates
    drive_sample(32'd9000, 16'd0, 32'd0);                 // exactly the end timeout
    drive_sample(32'd9001, 16'd0, 32'd0);                 // short session ends, not saved
    drive_sample(32'd9002, 16'd1000, 32'd5);              // immediate restart
    drive_sample(32'd19002, 16'd0, 32'd0);                // no samples, exactly the minimum
    drive_sample(32'hFFFF_F000, 16'd700, 32'd10);
    drive_sample(32'h0000_0100, 16'hFFFF, 32'h7FFF_FFFF); // time wraps inside the session
    drive_sample(32'h0000_3000, 16'd800, 32'd20);
    drive_sample(32'h0000_4389, 16'd0, 32'd0);            // saved, daily distance reaches its maximum
    drive_sample(32'h0000_5000, 16'd100, 32'd0);          // unloaded clears the seen flag
    drive_sample(32'h0000_5001, 16'd900, 32'd0);
    drive_sample(32'h0000_57D2, 16'd900, 32'd0);
    drive_sample(32'h0000_57D3, 16'd0, 32'd0);
    wait_idle();

    run_phase(150, IDLE_NONE);
    set_config(16'd0, 16'd0, 16'd0, 32'd0, 16'hFFFF);
    run_phase(150, IDLE_SENDER);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
    run_phase(40, IDLE_RECEIVER);
    set_config(16'($urandom_range(200, 60000)), 16'hFFFF, 16'hFFFF,
               $urandom_range(0, 400000), 16'($urandom));
    run_phase(150, IDLE_BOTH);
    for (int ph = 0; ph < 5; ph++) begin
      set_config(16'($urandom_range(0, 40000)), 16'($urandom_range(0, 300)),
                 16'($urandom_range(0, 300)), $urandom_range(0, 3000), 16'($urandom));
      run_phase(130, idle_mode_e'(ph % 4));
    end
    set_config(16'($urandom_range(0, 40000)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 300)), 32'hFFFF_FFFF, 16'($urandom));
    run_phase(100, IDLE_SENDER);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> usage_session_tracker.f
+incdir+rtl
rtl/ust_pkg.sv
rtl/ust_divider.sv
rtl/usage_session_tracker.sv
rtl/ust_checker.sv
sim/tb.sv
